@@ rtl/amdfs_pkg.sv @@
// Shared types and constants for the adjacency-matrix depth-first traversal block.
package amdfs_pkg;

    // Item codes carried in the mode field.
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_EDGE  = 2'd1;
    localparam logic [1:0] MODE_LABEL = 2'd2;
    localparam logic [1:0] MODE_RUN   = 2'd3;

    // The only weight that makes two vertices adjacent.
    localparam logic [15:0] EDGE_ADJ_WEIGHT = 16'd1;

    // Vertex count after reset.
    localparam logic [4:0] VERTEX_COUNT_RESET = 5'd16;

    // Neighbor search examines this many columns per cycle.
    localparam int CHUNK_BITS  = 8;
    localparam int CHUNK_IDX_W = 3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  first_vertex;
        logic [3:0]  second_vertex;
        logic [15:0] edge_weight;
        logic [7:0]  vertex_label;
    } in_item_t;

    typedef struct packed {
        logic [3:0] visited_vertex;
        logic [7:0] visited_label;
        logic       new_component;
        logic       last_vertex;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR_RD,
        ST_CLR_WR,
        ST_EDGE_RD_A,
        ST_EDGE_WR_A,
        ST_EDGE_RD_B,
        ST_EDGE_WR_B,
        ST_ROOT,
        ST_VISIT_RD,
        ST_VISIT_EMIT,
        ST_ROW_RD,
        ST_ROW_LOAD,
        ST_SEARCH,
        ST_POP_RD,
        ST_POP_TOP
    } state_t;

endpackage

@@ rtl/amdfs_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module amdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read data is registered every cycle; a read of the entry written in the same
    // cycle returns its old contents.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/adjacency_matrix_dfs_order.sv @@
// A label write completes on acceptance; an edge write reads and rewrites row a, then row b;
// a clear reads and rewrites each row in use. A run emits n results, visiting each vertex
// (label read, then emit), scanning the top vertex's adjacency row in groups of 8 columns,
// popping the stack and searching for the next root; results can stall it. One item at a time.
// Reset (aresetn, synchronous, active low) clears control state and the per-row valid bits,
// so the matrix and labels read as zero at once without a clearing pass.
module adjacency_matrix_dfs_order
    import amdfs_pkg::*;
#(
    parameter int MAX_VERTICES = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_wr_en,
    input  logic [4:0] cfg_wr_data
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int NW  = $clog2(MAX_VERTICES + 1);
    localparam int NCH = (MAX_VERTICES + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int PW  = NCH * CHUNK_BITS;
    localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;

    state_t state_reg, state_next;

    logic [4:0]              vcount_reg, vcount_next;
    logic [MAX_VERTICES-1:0] row_valid_reg, row_valid_next;
    logic [MAX_VERTICES-1:0] lbl_valid_reg, lbl_valid_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [NW-1:0]           cnt_reg, cnt_next;
    logic [NW-1:0]           k_reg, k_next;
    logic [NW-1:0]           depth_reg, depth_next;
    logic [VW-1:0]           top_reg, top_next;
    logic [VW-1:0]           vis_reg, vis_next;
    logic                    root_reg, root_next;
    logic [VW-1:0]           a_reg, a_next;
    logic [VW-1:0]           b_reg, b_next;
    logic                    w1_reg, w1_next;
    logic [PW-1:0]           cand_reg, cand_next;
    logic [CHW-1:0]          chunk_reg, chunk_next;
    logic [VW-1:0]           adj_rq_reg;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg, m_data_next;

    // RAM ports.
    logic                    adj_we;
    logic [VW-1:0]           adj_waddr, adj_raddr;
    logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;
    logic                    lbl_we;
    logic [VW-1:0]           lbl_waddr;
    logic [7:0]              lbl_wdata, lbl_rdata;
    logic                    stk_we;
    logic [VW-1:0]           stk_waddr, stk_rdata;
    logic [NW-1:0]           stk_rd_idx;

    logic                    s_fire;
    logic                    out_free;
    logic [NW-1:0]           n_live;
    logic [MAX_VERTICES-1:0] live_mask;
    logic [MAX_VERTICES-1:0] row_data;
    logic [7:0]              label_data;
    logic [CHUNK_BITS-1:0]   chunk_bits;
    logic                    chunk_hit;
    logic [CHUNK_IDX_W-1:0]  chunk_idx;
    logic [VW-1:0]           found_vertex;
    logic                    is_last;
    logic                    a_in_range, b_in_range;

    amdfs_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
        .clk(aclk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
        .raddr(adj_raddr), .rdata(adj_rdata)
    );

    amdfs_ram #(.WIDTH(8), .DEPTH(MAX_VERTICES)) u_lbl_ram (
        .clk(aclk), .we(lbl_we), .waddr(lbl_waddr), .wdata(lbl_wdata),
        .raddr(vis_reg), .rdata(lbl_rdata)
    );

    amdfs_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stk_ram (
        .clk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(vis_reg),
        .raddr(stk_rd_idx[VW-1:0]), .rdata(stk_rdata)
    );

    // Handshake and output register.
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Vertex count in use, capped at the matrix size, and its column mask.
    always_comb begin
        if (int'(vcount_reg) > MAX_VERTICES) begin
            n_live = NW'(MAX_VERTICES);
        end else begin
            n_live = NW'(vcount_reg);
        end
        for (int j = 0; j < MAX_VERTICES; j++) begin
            live_mask[j] = (NW'(j) < n_live);
        end
    end

    // Rows and labels never written read as zero.
    assign row_data   = row_valid_reg[adj_rq_reg] ? adj_rdata : '0;
    assign label_data = lbl_valid_reg[vis_reg] ? lbl_rdata : '0;

    assign a_in_range = (int'(s_data.first_vertex) < MAX_VERTICES);
    assign b_in_range = (int'(s_data.second_vertex) < MAX_VERTICES);
    assign stk_rd_idx = depth_reg - 1'b1;
    assign is_last    = ((k_reg + 1'b1) == n_live);

    // Lowest candidate neighbor in the current group of columns.
    always_comb begin
        chunk_bits = cand_reg[chunk_reg*CHUNK_BITS +: CHUNK_BITS];
        chunk_hit  = 1'b0;
        chunk_idx  = '0;
        for (int b = CHUNK_BITS - 1; b >= 0; b--) begin
            if (chunk_bits[b]) begin
                chunk_hit = 1'b1;
                chunk_idx = CHUNK_IDX_W'(b);
            end
        end
        found_vertex = VW'({chunk_reg, chunk_idx});
    end

    // Adjacency read address follows the row that the current step works on.
    always_comb begin
        case (state_reg)
            ST_CLR_RD, ST_CLR_WR:         adj_raddr = cnt_reg[VW-1:0];
            ST_EDGE_RD_A, ST_EDGE_WR_A:   adj_raddr = a_reg;
            ST_EDGE_RD_B, ST_EDGE_WR_B:   adj_raddr = b_reg;
            default:                      adj_raddr = top_reg;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state, datapath updates and RAM controls.
    always_comb begin
        state_next     = state_reg;
        vcount_next    = cfg_wr_en ? cfg_wr_data : vcount_reg;
        row_valid_next = row_valid_reg;
        lbl_valid_next = lbl_valid_reg;
        visited_next   = visited_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        depth_next     = depth_reg;
        top_next       = top_reg;
        vis_next       = vis_reg;
        root_next      = root_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        w1_next        = w1_reg;
        cand_next      = cand_reg;
        chunk_next     = chunk_reg;
        m_valid_next   = m_ready ? 1'b0 : m_valid_reg;
        m_data_next    = m_data_reg;
        adj_we         = 1'b0;
        adj_waddr      = adj_rq_reg;
        adj_wdata      = row_data;
        lbl_we         = 1'b0;
        lbl_waddr      = VW'(s_data.first_vertex);
        lbl_wdata      = s_data.vertex_label;
        stk_we         = 1'b0;
        stk_waddr      = depth_reg[VW-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_data.mode)
                        MODE_CLEAR: begin
                            cnt_next = '0;
                            if (n_live != '0) begin
                                state_next = ST_CLR_RD;
                            end
                        end
                        MODE_EDGE: begin
                            a_next  = VW'(s_data.first_vertex);
                            b_next  = VW'(s_data.second_vertex);
                            w1_next = (s_data.edge_weight == EDGE_ADJ_WEIGHT);
                            if (a_in_range && b_in_range) begin
                                state_next = ST_EDGE_RD_A;
                            end
                        end
                        MODE_LABEL: begin
                            if (a_in_range) begin
                                lbl_we = 1'b1;
                                lbl_valid_next[VW'(s_data.first_vertex)] = 1'b1;
                            end
                        end
                        MODE_RUN: begin
                            visited_next = '0;
                            depth_next   = '0;
                            k_next       = '0;
                            cnt_next     = '0;
                            if (n_live != '0) begin
                                state_next = ST_ROOT;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Clear sweep: drop the columns in use from each row in use.
            ST_CLR_RD: begin
                state_next = ST_CLR_WR;
            end
            ST_CLR_WR: begin
                adj_we    = 1'b1;
                adj_waddr = cnt_reg[VW-1:0];
                adj_wdata = row_data & ~live_mask;
                row_valid_next[cnt_reg[VW-1:0]] = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                state_next = ((cnt_reg + 1'b1) == n_live) ? ST_IDLE : ST_CLR_RD;
            end

            // Edge write: modify row a at column b, then row b at column a.
            ST_EDGE_RD_A: begin
                state_next = ST_EDGE_WR_A;
            end
            ST_EDGE_WR_A: begin
                adj_we    = 1'b1;
                adj_waddr = a_reg;
                adj_wdata = row_data;
                adj_wdata[b_reg] = w1_reg;
                row_valid_next[a_reg] = 1'b1;
                state_next = ST_EDGE_RD_B;
            end
            ST_EDGE_RD_B: begin
                state_next = ST_EDGE_WR_B;
            end
            ST_EDGE_WR_B: begin
                adj_we    = 1'b1;
                adj_waddr = b_reg;
                adj_wdata = row_data;
                adj_wdata[a_reg] = w1_reg;
                row_valid_next[b_reg] = 1'b1;
                state_next = ST_IDLE;
            end

            // Find the lowest unvisited vertex to start the next tree.
            ST_ROOT: begin
                if (cnt_reg >= n_live) begin
                    state_next = ST_IDLE;
                end else if (visited_reg[cnt_reg[VW-1:0]]) begin
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    vis_next   = cnt_reg[VW-1:0];
                    root_next  = 1'b1;
                    state_next = ST_VISIT_RD;
                end
            end

            // Label read for the vertex being visited.
            ST_VISIT_RD: begin
                state_next = ST_VISIT_EMIT;
            end

            // Emit the vertex, mark it and push it on the stack.
            ST_VISIT_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next.visited_vertex = 4'(vis_reg);
                    m_data_next.visited_label  = label_data;
                    m_data_next.new_component  = root_reg;
                    m_data_next.last_vertex    = is_last;
                    visited_next[vis_reg] = 1'b1;
                    k_next = k_reg + 1'b1;
                    if (depth_reg < NW'(MAX_VERTICES)) begin
                        stk_we     = 1'b1;
                        depth_next = depth_reg + 1'b1;
                        top_next   = vis_reg;
                    end
                    state_next = is_last ? ST_IDLE : ST_ROW_RD;
                end
            end

            // Read the top vertex's row and keep its unvisited live neighbors.
            ST_ROW_RD: begin
                state_next = ST_ROW_LOAD;
            end
            ST_ROW_LOAD: begin
                cand_next  = PW'(row_data & ~visited_reg & live_mask);
                chunk_next = '0;
                state_next = ST_SEARCH;
            end

            // Search one group of columns per cycle; pop when none is left.
            ST_SEARCH: begin
                if (chunk_hit) begin
                    vis_next   = found_vertex;
                    root_next  = 1'b0;
                    state_next = ST_VISIT_RD;
                end else if (chunk_reg == CHW'(NCH - 1)) begin
                    depth_next = depth_reg - 1'b1;
                    state_next = (depth_reg == NW'(1)) ? ST_ROOT : ST_POP_RD;
                end else begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end

            // Fetch the new top of the stack after a pop.
            ST_POP_RD: begin
                state_next = ST_POP_TOP;
            end
            ST_POP_TOP: begin
                top_next   = stk_rdata;
                state_next = ST_ROW_RD;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg    <= VERTEX_COUNT_RESET;
            row_valid_reg <= '0;
            lbl_valid_reg <= '0;
            visited_reg   <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            depth_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            vcount_reg    <= vcount_next;
            row_valid_reg <= row_valid_next;
            lbl_valid_reg <= lbl_valid_next;
            visited_reg   <= visited_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            depth_reg     <= depth_next;
            m_valid_reg   <= m_valid_next;
        end
        top_reg    <= top_next;
        vis_reg    <= vis_next;
        root_reg   <= root_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        w1_reg     <= w1_next;
        cand_reg   <= cand_next;
        chunk_reg  <= chunk_next;
        adj_rq_reg <= adj_raddr;
        m_data_reg <= m_data_next;
    end

    // A vertex is emitted only once per run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_VISIT_EMIT) |-> !visited_reg[vis_reg])
        else $error("vertex emitted twice in one traversal");

    // A run never emits more vertices than are in use.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_VISIT_EMIT) |-> (k_reg < n_live))
        else $error("traversal emitted too many vertices");

    // The neighbor search always works on a non-empty stack.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH || state_reg == ST_ROW_LOAD) |-> (depth_reg != '0))
        else $error("neighbor search with an empty stack");

    // The final vertex of a run returns the block to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_VISIT_EMIT && out_free && is_last) |=> (state_reg == ST_IDLE))
        else $error("traversal continued after its final vertex");

endmodule

@@ tb/adjacency_matrix_dfs_order_tb.sv @@
// Self-checking testbench for the adjacency-matrix depth-first traversal block.
module adjacency_matrix_dfs_order_tb
    import amdfs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CLK_PERIOD    = 8;
    localparam int  RESET_CYCLES  = 10;
    localparam int  NUM_VERTICES  = 16;
    localparam int  RANDOM_ITEMS  = 500;
    localparam int  DRAIN_CYCLES  = 64;
    localparam int  QUIET_LIMIT   = 5000;

    // Clock, reset and block ports; the ones driven here are known from time zero.
    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    in_item_t   s_data      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    out_item_t  m_data;
    logic       cfg_wr_en   = 1'b0;
    logic [4:0] cfg_wr_data = '0;

    // Items waiting to be sent, and visits predicted but not yet seen.
    in_item_t  pending_items [$];
    out_item_t expected_visits [$];

    // Local copy of the block's graph, labels and vertex count.
    logic [15:0] adj_rows   [NUM_VERTICES] = '{default: '0};
    logic [7:0]  label_copy [NUM_VERTICES] = '{default: '0};
    logic [4:0]  vertex_limit = VERTEX_COUNT_RESET;

    int error_count  = 0;
    int items_queued = 0;
    int quiet_cycles = 0;
    int send_gap     = 0;
    int take_gap     = 0;
    bit send_calm    = 1'b0;
    bit take_calm    = 1'b0;

    adjacency_matrix_dfs_order #(
        .MAX_VERTICES(NUM_VERTICES)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Number of vertices that clears and traversals actually use.
    function automatic int live_vertices();
        return (vertex_limit > NUM_VERTICES) ? NUM_VERTICES : int'(vertex_limit);
    endfunction

    // Depth-first walk over the local matrix; queues one visit per vertex in use.
    function automatic void predict_dfs_visits(int n);
        logic [15:0] seen;
        int          stack [NUM_VERTICES];
        int          depth;
        int          visits;
        int          top;
        int          nb;
        out_item_t   v;
        seen   = '0;
        visits = 0;
        for (int i = 0; i < n; i++) begin
            if (!seen[i]) begin
                seen[i] = 1'b1;
                v.visited_vertex = 4'(i);
                v.visited_label  = label_copy[i];
                v.new_component  = 1'b1;
                v.last_vertex    = (visits + 1 == n);
                expected_visits = {expected_visits, v};
                visits++;
                stack[0] = i;
                depth    = 1;
                while (depth > 0) begin
                    top = stack[depth - 1];
                    nb  = n;
                    for (int j = n - 1; j >= 0; j--) begin
                        if (adj_rows[top][j] && !seen[j]) nb = j;
                    end
                    if (nb >= n) begin
                        depth--;
                    end else begin
                        seen[nb] = 1'b1;
                        v.visited_vertex = 4'(nb);
                        v.visited_label  = label_copy[nb];
                        v.new_component  = 1'b0;
                        v.last_vertex    = (visits + 1 == n);
                        expected_visits = {expected_visits, v};
                        visits++;
                        if (depth < NUM_VERTICES) begin
                            stack[depth] = nb;
                            depth++;
                        end
                    end
                end
            end
        end
    endfunction

    // Update the local state for one accepted item.
    function automatic void apply_item(in_item_t it);
        int n;
        n = live_vertices();
        case (it.mode)
            MODE_CLEAR: begin
                for (int i = 0; i < n; i++)
                    for (int j = 0; j < n; j++)
                        adj_rows[i][j] = 1'b0;
            end
            MODE_EDGE: begin
                adj_rows[it.first_vertex][it.second_vertex] = (it.edge_weight == EDGE_ADJ_WEIGHT);
                adj_rows[it.second_vertex][it.first_vertex] = (it.edge_weight == EDGE_ADJ_WEIGHT);
            end
            MODE_LABEL: begin
                label_copy[it.first_vertex] = it.vertex_label;
            end
            MODE_RUN: begin
                predict_dfs_visits(n);
            end
            default: begin
            end
        endcase
    endfunction

    // Wait count before the next transfer; now and then switch between busy and calm.
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 19) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    function automatic in_item_t make_item(logic [1:0] mode, logic [3:0] a, logic [3:0] b,
                                           logic [15:0] w, logic [7:0] lab);
        in_item_t it;
        it.mode          = mode;
        it.first_vertex  = a;
        it.second_vertex = b;
        it.edge_weight   = w;
        it.vertex_label  = lab;
        return it;
    endfunction

    // Mostly a vertex in use, sometimes any index.
    function automatic logic [3:0] pick_vertex(int n);
        if (n > 0 && $urandom_range(0, 3) != 0) return 4'($urandom_range(0, n - 1));
        return 4'($urandom_range(0, NUM_VERTICES - 1));
    endfunction

    function automatic in_item_t random_item(logic [1:0] mode, int n);
        return make_item(mode, pick_vertex(n), pick_vertex(n), 16'($urandom), 8'($urandom));
    endfunction

    task automatic queue_item(in_item_t it);
        pending_items = {pending_items, it};
        items_queued++;
    endtask

    // One graph session: optional clear, labels, edges, then a traversal; or else a burst of noise items.
    task automatic queue_session(int n);
        in_item_t it;
        int       perm [NUM_VERTICES];
        int       span;
        int       j;
        int       tmp;
        span = (n == 0) ? NUM_VERTICES : n;
        if ($urandom_range(0, 4) == 0) begin
            // Noise: a few items of any kind with any content.
            repeat ($urandom_range(1, 4)) queue_item(random_item(2'($urandom), n));
            return;
        end
        if ($urandom_range(0, 1) == 0) queue_item(random_item(MODE_CLEAR, n));
        repeat ($urandom_range(0, 4)) queue_item(random_item(MODE_LABEL, n));
        if ($urandom_range(0, 3) == 0) begin
            // A shuffled path through every vertex in use builds a deep stack.
            for (int i = 0; i < NUM_VERTICES; i++) perm[i] = i;
            for (int i = span - 1; i > 0; i--) begin
                j       = $urandom_range(0, i);
                tmp     = perm[i];
                perm[i] = perm[j];
                perm[j] = tmp;
            end
            for (int i = 0; i + 1 < span; i++) begin
                it = random_item(MODE_EDGE, n);
                it.first_vertex  = 4'(perm[i]);
                it.second_vertex = 4'(perm[i + 1]);
                it.edge_weight   = EDGE_ADJ_WEIGHT;
                queue_item(it);
            end
        end else begin
            repeat ($urandom_range(0, 2 * span + 2)) begin
                it = random_item(MODE_EDGE, n);
                if ($urandom_range(0, 3) != 0) it.edge_weight = EDGE_ADJ_WEIGHT;
                queue_item(it);
            end
        end
        queue_item(random_item(MODE_RUN, n));
    endtask

    // Wait until every item is sent and every visit seen, then let the block finish.
    task automatic settle();
        while (pending_items.size() != 0 || s_valid || expected_visits.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_vertex_count(logic [4:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        vertex_limit = value;
    endtask

    // Input driver: presents queued items and predicts each one on its transfer.
    always @(posedge aclk) begin : drive_items
        logic next_valid;
        next_valid = s_valid;
        if (!aresetn) begin
            next_valid = 1'b0;
            send_gap   = 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_item(s_data);
                next_valid = 1'b0;
                send_gap   = draw_gap(send_calm);
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() > 0) begin
                    s_data     <= pending_items[0];
                    pending_items.delete(0);
                    next_valid = 1'b1;
                end
            end
        end
        s_valid <= next_valid;
    end

    // Result monitor: compares each visit transfer with the oldest prediction.
    always @(posedge aclk) begin : watch_visits
        out_item_t want;
        if (!aresetn) begin
            take_gap = 0;
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_visits.size() == 0) begin
                    $error("visit of vertex %0d arrived with none expected",
                           m_data.visited_vertex);
                    error_count++;
                end else begin
                    want = expected_visits[0];
                    expected_visits.delete(0);
                    check_field("visited_vertex", want.visited_vertex, m_data.visited_vertex);
                    check_field("visited_label", want.visited_label, m_data.visited_label);
                    check_field("new_component", want.new_component, m_data.new_component);
                    check_field("last_vertex", want.last_vertex, m_data.last_vertex);
                end
                take_gap = draw_gap(take_calm);
            end else if (take_gap > 0) begin
                take_gap--;
            end
            m_ready <= (take_gap == 0);
        end
    end

    // Watchdog on stretches with no transfer on either channel.
    always @(posedge aclk) begin : quiet_watch
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[adjacency_matrix_dfs_order] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus sequence: directed cases, then random phases over several vertex counts.
    initial begin : stimulus
        logic [4:0] count_menu [8];
        logic [4:0] count_now;
        int         phase;
        int         phase_start;
        count_menu = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31, 5'd8, 5'd3};
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty graph at the reset count: every vertex is its own tree.
        queue_item(make_item(MODE_RUN, 4'd0, 4'd0, 16'd0, 8'd0));
        queue_item(make_item(MODE_LABEL, 4'd0, 4'd15, 16'hFFFF, 8'hFF));
        queue_item(make_item(MODE_LABEL, 4'd15, 4'd0, 16'd0, 8'h5A));
        queue_item(make_item(MODE_LABEL, 4'd7, 4'd0, 16'd0, 8'hA5));
        queue_item(make_item(MODE_EDGE, 4'd0, 4'd15, EDGE_ADJ_WEIGHT, 8'd0));
        queue_item(make_item(MODE_EDGE, 4'd15, 4'd14, EDGE_ADJ_WEIGHT, 8'hFF));
        // Self loop is stored but never followed.
        queue_item(make_item(MODE_EDGE, 4'd3, 4'd3, EDGE_ADJ_WEIGHT, 8'd0));
        // Weights other than one do not make an edge.
        queue_item(make_item(MODE_EDGE, 4'd1, 4'd2, 16'hFFFF, 8'd0));
        queue_item(make_item(MODE_EDGE, 4'd2, 4'd4, 16'd0, 8'd0));
        queue_item(make_item(MODE_EDGE, 4'd4, 4'd5, 16'd2, 8'd0));
        queue_item(make_item(MODE_EDGE, 4'd14, 4'd1, EDGE_ADJ_WEIGHT, 8'd0));
        queue_item(make_item(MODE_EDGE, 4'd1, 4'd7, EDGE_ADJ_WEIGHT, 8'd0));
        queue_item(make_item(MODE_RUN, 4'd15, 4'd15, 16'hFFFF, 8'hFF));
        // Rewriting with another weight removes the edge both ways.
        queue_item(make_item(MODE_EDGE, 4'd15, 4'd0, 16'hFFFF, 8'd0));
        queue_item(make_item(MODE_RUN, 4'd0, 4'd0, 16'd0, 8'd0));
        settle();

        // Partial clear keeps edges that reach vertices outside the count.
        write_vertex_count(5'd5);
        queue_item(make_item(MODE_EDGE, 4'd0, 4'd4, EDGE_ADJ_WEIGHT, 8'd0));
        queue_item(make_item(MODE_EDGE, 4'd3, 4'd9, EDGE_ADJ_WEIGHT, 8'd0));
        queue_item(make_item(MODE_RUN, 4'd0, 4'd0, 16'd0, 8'd0));
        queue_item(make_item(MODE_CLEAR, 4'd0, 4'd0, 16'd0, 8'd0));
        queue_item(make_item(MODE_RUN, 4'd0, 4'd0, 16'd0, 8'd0));
        settle();
        write_vertex_count(5'd16);
        queue_item(make_item(MODE_RUN, 4'd0, 4'd0, 16'd0, 8'd0));
        settle();
        // A zero count emits nothing and clears nothing.
        write_vertex_count(5'd0);
        queue_item(make_item(MODE_CLEAR, 4'd0, 4'd0, 16'd0, 8'd0));
        queue_item(make_item(MODE_RUN, 4'd0, 4'd0, 16'd0, 8'd0));
        settle();
        // A count above the matrix size acts as the full size.
        write_vertex_count(5'd31);
        queue_item(make_item(MODE_RUN, 4'd0, 4'd0, 16'd0, 8'd0));
        settle();

        // Random phases, each at its own vertex count.
        items_queued = 0;
        phase        = 0;
        while (items_queued < RANDOM_ITEMS) begin
            if (phase < 8) count_now = count_menu[phase];
            else if ($urandom_range(0, 1) == 0) count_now = 5'($urandom_range(0, 31));
            else count_now = 5'($urandom_range(1, NUM_VERTICES));
            write_vertex_count(count_now);
            phase_start = items_queued;
            while (items_queued - phase_start < 40) queue_session(live_vertices());
            settle();
            phase++;
        end

        settle();
        if (error_count == 0) begin
            $display("[adjacency_matrix_dfs_order] OK");
        end else begin
            $display("[adjacency_matrix_dfs_order] ERROR");
        end
        $finish;
    end

endmodule
